// ===== src/spherical_voxel_index_macros.svh =====
// Assertion macros for the spherical voxel indexer.
`ifndef SPHERICAL_VOXEL_INDEX_MACROS_SVH
`define SPHERICAL_VOXEL_INDEX_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SVI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SVI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/svi_pkg.sv =====
// Shared types, constants and tables for the spherical voxel indexer.
package svi_pkg;

  localparam int CordicIters = 24;
  localparam int GuardBits   = 8;
  localparam int Cw          = 46;
  localparam int MagW        = Cw - 1;
  localparam int Aw          = 34;
  localparam int AngU        = Aw - 1;
  localparam int RsW         = MagW + 16;
  localparam int AsW         = AngU + 16;
  localparam int CordicLat   = CordicIters + 1;

  typedef logic signed [Cw-1:0] coord_t;
  typedef logic signed [Aw-1:0] angle_t;

  localparam angle_t PiQ28     = 34'sd843314857;
  localparam angle_t HalfPiQ28 = 34'sd421657428;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [30:0] Max31 = 31'h7FFFFFFF;
  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef enum logic [2:0] {
    RegOriginX        = 3'd0,
    RegOriginY        = 3'd1,
    RegOriginZ        = 3'd2,
    RegInvLeafRadius  = 3'd3,
    RegInvLeafPolar   = 3'd4,
    RegInvLeafAzimuth = 3'd5,
    RegPolarDiv       = 3'd6,
    RegAzimuthDiv     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        point_id;
    logic               point_ok;
  } in_req_t;

  typedef struct packed {
    logic [30:0] cell_index;
    logic [30:0] radial_index;
    logic [15:0] polar_index;
    logic [15:0] azimuth_index;
    logic [31:0] point_tag;
    logic        index_overflow;
  } out_rsp_t;

  function automatic angle_t atan_q28(input int unsigned i);
    angle_t v;
    case (i)
      0:  v = 34'sd210828714;
      1:  v = 34'sd124459457;
      2:  v = 34'sd65760959;
      3:  v = 34'sd33381290;
      4:  v = 34'sd16755422;
      5:  v = 34'sd8385879;
      6:  v = 34'sd4193963;
      7:  v = 34'sd2097109;
      8:  v = 34'sd1048571;
      9:  v = 34'sd524287;
      10: v = 34'sd262144;
      11: v = 34'sd131072;
      12: v = 34'sd65536;
      13: v = 34'sd32768;
      14: v = 34'sd16384;
      15: v = 34'sd8192;
      16: v = 34'sd4096;
      17: v = 34'sd2048;
      18: v = 34'sd1024;
      19: v = 34'sd512;
      20: v = 34'sd256;
      21: v = 34'sd128;
      22: v = 34'sd64;
      23: v = 34'sd32;
      24: v = 34'sd16;
      25: v = 34'sd8;
      26: v = 34'sd4;
      27: v = 34'sd2;
      28: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/svi_cordic.sv =====
// Pipelined CORDIC vectoring unit: one register stage for the quadrant pre-rotation and one per iteration.
module svi_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  svi_pkg::coord_t x_i,
  input  svi_pkg::coord_t y_i,
  output logic           vld_o,
  output svi_pkg::coord_t mag_o,
  output svi_pkg::angle_t ang_o
);
  import svi_pkg::*;

  logic   vld_q  [CordicLat];
  logic   zero_q [CordicLat];
  coord_t x_q    [CordicLat];
  coord_t y_q    [CordicLat];
  angle_t a_q    [CordicLat];

  coord_t x_d    [CordicLat];
  coord_t y_d    [CordicLat];
  angle_t a_d    [CordicLat];

  always_comb begin
    x_d[0] = x_i;
    y_d[0] = y_i;
    a_d[0] = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_d[0] = y_i;
        y_d[0] = -x_i;
        a_d[0] = HalfPiQ28;
      end else begin
        x_d[0] = -y_i;
        y_d[0] = x_i;
        a_d[0] = -HalfPiQ28;
      end
    end
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    coord_t xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_comb begin
      if (y_q[i] >= 0) begin
        x_d[i+1] = x_q[i] + ys;
        y_d[i+1] = y_q[i] - xs;
        a_d[i+1] = a_q[i] + atan_q28(i);
      end else begin
        x_d[i+1] = x_q[i] - ys;
        y_d[i+1] = y_q[i] + xs;
        a_d[i+1] = a_q[i] - atan_q28(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CordicLat; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < CordicLat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      for (int k = 1; k < CordicLat; k++) zero_q[k] <= zero_q[k-1];
      for (int k = 0; k < CordicLat; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        a_q[k] <= a_d[k];
      end
    end
  end

  assign vld_o = vld_q[CordicLat-1];
  assign mag_o = x_q[CordicLat-1];
  assign ang_o = zero_q[CordicLat-1] ? angle_t'(0) : a_q[CordicLat-1];

endmodule

// ===== src/svi_gain.sv =====
// Two-stage multiply by the inverse CORDIC gain, floored.
module svi_gain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  svi_pkg::coord_t mag_i,
  output logic           vld_o,
  output svi_pkg::coord_t mag_o
);
  import svi_pkg::*;

  localparam int PhW = MagW - 16 + 30;
  localparam int PlW = 16 + 30;

  logic [MagW-1:0] a;
  logic [PhW-1:0]  ph_q;
  logic [PlW-1:0]  pl_q;
  logic [PhW:0]    sum;
  logic            v1_q, v2_q;
  coord_t          mag_q;

  assign a   = (mag_i > 0) ? mag_i[MagW-1:0] : '0;
  assign sum = (PhW+1)'(ph_q) + (PhW+1)'(pl_q >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q  <= PhW'(a[MagW-1:16]) * PhW'(InvGainQ30);
      pl_q  <= PlW'(a[15:0]) * PlW'(InvGainQ30);
      mag_q <= $signed(Cw'(sum >> 14));
    end
  end

  assign vld_o = v2_q;
  assign mag_o = mag_q;

endmodule

// ===== src/spherical_voxel_index.sv =====
// Top level of the spherical voxel indexer.
//
// Input channel: in_valid_i / in_ready_o with in_req_i (coordinates, id, ok flag).
// A request with point_ok low is accepted and dropped; it gives no result.
// Output channel: out_valid_o / out_ready_i with out_rsp_o (indices, tag, overflow).
// Configuration: APB-style write/read port, pready always high; registers at 4*i.
// Write configuration only while no request is in flight.
// Stages from acceptance to result: two 25-stage CORDIC pipelines,
// two 2-stage gain multipliers and five stages of subtract, scale and combine.
// Throughput: one request per cycle while in_ready_o is high.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the output register holds its result; the pipeline keeps
// advancing into empty slots and freezes only when a result waits behind the output
// register, at which point in_ready_o drops.
module spherical_voxel_index (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  svi_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output svi_pkg::out_rsp_t out_rsp_o
);
  import svi_pkg::*;
  `include "spherical_voxel_index_macros.svh"

  localparam int SideAW = Cw + 32;
  localparam int SideBW = Aw + 32;
  localparam int SideLen = CordicLat + 2;

  logic [31:0] org_x_q, org_y_q, org_z_q;
  logic [31:0] ilr_q, ilp_q, ila_q;
  logic [15:0] pd_q, ad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      ilr_q   <= 32'd65536;
      ilp_q   <= 32'd65536;
      ila_q   <= 32'd65536;
      pd_q    <= 16'd1;
      ad_q    <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[4:2]))
        RegOriginX:        org_x_q <= pwdata;
        RegOriginY:        org_y_q <= pwdata;
        RegOriginZ:        org_z_q <= pwdata;
        RegInvLeafRadius:  ilr_q   <= pwdata;
        RegInvLeafPolar:   ilp_q   <= pwdata;
        RegInvLeafAzimuth: ila_q   <= pwdata;
        RegPolarDiv:       pd_q    <= pwdata[15:0];
        RegAzimuthDiv:     ad_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      RegOriginX:        prdata = org_x_q;
      RegOriginY:        prdata = org_y_q;
      RegOriginZ:        prdata = org_z_q;
      RegInvLeafRadius:  prdata = ilr_q;
      RegInvLeafPolar:   prdata = ilp_q;
      RegInvLeafAzimuth: prdata = ila_q;
      RegPolarDiv:       prdata = {16'b0, pd_q};
      RegAzimuthDiv:     prdata = {16'b0, ad_q};
      default:           prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  logic en, fa_vld_q, out_valid_q;
  assign en         = out_ready_i || !out_valid_q || !fa_vld_q;
  assign in_ready_o = en;

  // subtract origin
  logic signed [32:0] diff_x, diff_y, diff_z;
  logic   s0_vld_q;
  coord_t dx_q, dy_q, dz_q;
  logic [31:0] s0_id_q;

  assign diff_x = $signed({in_req_i.coord_x[31], in_req_i.coord_x}) - $signed({org_x_q[31], org_x_q});
  assign diff_y = $signed({in_req_i.coord_y[31], in_req_i.coord_y}) - $signed({org_y_q[31], org_y_q});
  assign diff_z = $signed({in_req_i.coord_z[31], in_req_i.coord_z}) - $signed({org_z_q[31], org_z_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i && in_req_i.point_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= $signed({{(Cw-33-GuardBits){diff_x[32]}}, diff_x, {GuardBits{1'b0}}});
      dy_q    <= $signed({{(Cw-33-GuardBits){diff_y[32]}}, diff_y, {GuardBits{1'b0}}});
      dz_q    <= $signed({{(Cw-33-GuardBits){diff_z[32]}}, diff_z, {GuardBits{1'b0}}});
      s0_id_q <= in_req_i.point_id;
    end
  end

  // planar pass
  logic   c1_vld, g1_vld;
  coord_t c1_mag, g1_mag;
  angle_t c1_ang;

  svi_cordic u_cordic_xy (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s0_vld_q), .x_i(dx_q), .y_i(dy_q),
    .vld_o(c1_vld), .mag_o(c1_mag), .ang_o(c1_ang)
  );

  svi_gain u_gain_xy (
    .clk_i, .rst_ni, .en_i(en), .vld_i(c1_vld), .mag_i(c1_mag),
    .vld_o(g1_vld), .mag_o(g1_mag)
  );

  logic [SideAW-1:0] side_a_q [SideLen];
  angle_t            az_dly_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q[0] <= {dz_q, s0_id_q};
      for (int k = 1; k < SideLen; k++) side_a_q[k] <= side_a_q[k-1];
      az_dly_q[0] <= c1_ang;
      az_dly_q[1] <= az_dly_q[0];
    end
  end

  coord_t g1_dz;
  assign g1_dz = $signed(side_a_q[SideLen-1][SideAW-1:32]);

  // polar pass
  logic   c2_vld, g2_vld;
  coord_t c2_mag, g2_mag;
  angle_t c2_ang;

  svi_cordic u_cordic_rz (
    .clk_i, .rst_ni, .en_i(en), .vld_i(g1_vld), .x_i(g1_dz), .y_i(g1_mag),
    .vld_o(c2_vld), .mag_o(c2_mag), .ang_o(c2_ang)
  );

  svi_gain u_gain_rz (
    .clk_i, .rst_ni, .en_i(en), .vld_i(c2_vld), .mag_i(c2_mag),
    .vld_o(g2_vld), .mag_o(g2_mag)
  );

  logic [SideBW-1:0] side_b_q [SideLen];
  angle_t            po_dly_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q[0] <= {side_a_q[SideLen-1][31:0], az_dly_q[1]};
      for (int k = 1; k < SideLen; k++) side_b_q[k] <= side_b_q[k-1];
      po_dly_q[0] <= c2_ang;
      po_dly_q[1] <= po_dly_q[0];
    end
  end

  angle_t az_s, az_c, po_c;
  assign az_s = $signed(side_b_q[SideLen-1][Aw-1:0]) + PiQ28;
  assign az_c = (az_s < 0) ? angle_t'(0) : az_s;
  assign po_c = (po_dly_q[1] < 0) ? angle_t'(0) : po_dly_q[1];

  // scale products
  logic            k1_vld_q;
  logic [RsW-1:0]  k1_rh_q, k1_rl_q;
  logic [AsW-1:0]  k1_ph_q, k1_pl_q, k1_ah_q, k1_al_q;
  logic [31:0]     k1_pdad_q, k1_id_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_rh_q   <= RsW'(g2_mag[MagW-1:0]) * RsW'(ilr_q[31:16]);
      k1_rl_q   <= RsW'(g2_mag[MagW-1:0]) * RsW'(ilr_q[15:0]);
      k1_ph_q   <= AsW'(po_c[AngU-1:0]) * AsW'(ilp_q[31:16]);
      k1_pl_q   <= AsW'(po_c[AngU-1:0]) * AsW'(ilp_q[15:0]);
      k1_ah_q   <= AsW'(az_c[AngU-1:0]) * AsW'(ila_q[31:16]);
      k1_al_q   <= AsW'(az_c[AngU-1:0]) * AsW'(ila_q[15:0]);
      k1_pdad_q <= 32'(pd_q) * 32'(ad_q);
      k1_id_q   <= side_b_q[SideLen-1][SideBW-1:Aw];
    end
  end

  // scale sums and saturation
  logic [RsW:0] rsum, rsh;
  logic [AsW:0] psum, psh, asum, ash;
  assign rsum = (RsW+1)'(k1_rh_q) + (RsW+1)'(k1_rl_q >> 16);
  assign psum = (AsW+1)'(k1_ph_q) + (AsW+1)'(k1_pl_q >> 16);
  assign asum = (AsW+1)'(k1_ah_q) + (AsW+1)'(k1_al_q >> 16);
  assign rsh  = rsum >> (32 + GuardBits - 16);
  assign psh  = psum >> 28;
  assign ash  = asum >> 28;

  logic        k2_vld_q;
  logic [30:0] k2_rad_q;
  logic [15:0] k2_pol_q, k2_azi_q;
  logic [31:0] k2_pdad_q, k2_id_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k2_rad_q  <= (rsh > (RsW+1)'(Max31)) ? Max31 : rsh[30:0];
      k2_pol_q  <= (psh > (AsW+1)'(Max16)) ? Max16 : psh[15:0];
      k2_azi_q  <= (ash > (AsW+1)'(Max16)) ? Max16 : ash[15:0];
      k2_pdad_q <= k1_pdad_q;
      k2_id_q   <= k1_id_q;
    end
  end

  // flat index products
  logic [31:0] fa_t1_q;
  logic [62:0] fa_t2_q;
  logic [30:0] fa_rad_q;
  logic [15:0] fa_pol_q, fa_azi_q;
  logic [31:0] fa_id_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_t1_q  <= 32'(k2_pol_q) * 32'(ad_q);
      fa_t2_q  <= 63'(k2_pdad_q) * 63'(k2_rad_q);
      fa_rad_q <= k2_rad_q;
      fa_pol_q <= k2_pol_q;
      fa_azi_q <= k2_azi_q;
      fa_id_q  <= k2_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_vld_q <= 1'b0;
      k2_vld_q <= 1'b0;
      fa_vld_q <= 1'b0;
    end else if (en) begin
      k1_vld_q <= g2_vld;
      k2_vld_q <= k1_vld_q;
      fa_vld_q <= k2_vld_q;
    end
  end

  // combine and saturate into the output register
  logic [63:0] flat;
  logic        ovf;
  out_rsp_t    out_d, out_q;

  assign flat = 64'(fa_t1_q) + 64'(fa_t2_q) + 64'(fa_azi_q);
  assign ovf  = flat > 64'(Max31);

  always_comb begin
    out_d.cell_index     = ovf ? Max31 : flat[30:0];
    out_d.radial_index   = fa_rad_q;
    out_d.polar_index    = fa_pol_q;
    out_d.azimuth_index  = fa_azi_q;
    out_d.point_tag      = fa_id_q;
    out_d.index_overflow = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q <= fa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SVI_ASSERT_NOW(a_ovf_sat, out_valid_o && out_rsp_o.index_overflow, out_rsp_o.cell_index == Max31, "overflow without saturated index")
  `SVI_ASSERT_NOW(a_stall_freeze, fa_vld_q && out_valid_o && !out_ready_i, !in_ready_o, "pipeline advanced into a blocked output")
  `SVI_ASSERT_NEXT(a_drop_bad, in_valid_i && in_ready_o && !in_req_i.point_ok, !s0_vld_q, "dropped request entered the pipeline")

endmodule
